[rtl/core/sed_pkg.sv]
`default_nettype none

package sed_pkg;

  // field widths
  localparam int PIXEL_W    = 8;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CENTER_W   = 10;
  localparam int GRAD_W     = 11;
  localparam int MAG_W      = 11;
  localparam int SQ_W       = 2 * MAG_W;   // gx^2 + gy^2, even for the root loop
  localparam int PROD_W     = 20;          // one squared gradient, |g| <= 1020
  localparam int SUM_W      = 10;          // one weighted column or row sum
  localparam int OUT_BITS   = 2 * CENTER_W + 2 * GRAD_W + MAG_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

  // defaults
  localparam int DEF_MAX_LINE_WIDTH = 1024;
  localparam int DEF_MAX_ROWS       = 1024;
  localparam logic [CFG_W-1:0] RST_LINE_WIDTH     = 11'd16;
  localparam logic [CFG_W-1:0] RST_EDGE_THRESHOLD = 11'd100;
  localparam int MIN_LINE_WIDTH = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GRAD,
    ST_SQR,
    ST_SUM,
    ST_ROOT,
    ST_OUT
  } sed_state_t;

endpackage

`default_nettype wire

[rtl/core/sed_ram.sv]
`default_nettype none

module sed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/core/sed_isqrt.sv]
`default_nettype none

// Integer square root, one result bit per cycle.
module sed_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sed_pkg::SQ_W-1:0]  operand,
  output logic                      done,
  output logic [sed_pkg::MAG_W-1:0] root
);

  import sed_pkg::*;

  logic            busy;
  logic [SQ_W-1:0] rem_val;
  logic [SQ_W-1:0] root_acc;
  logic [SQ_W-1:0] bit_mask;
  logic [SQ_W-1:0] trial;

  assign trial = root_acc + bit_mask;
  assign done  = busy && bit_mask[0];
  assign root  = root_acc[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_val  <= operand;
      root_acc <= '0;
      bit_mask <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy) begin
      if (rem_val >= trial) begin
        rem_val  <= rem_val - trial;
        root_acc <= (root_acc >> 1) + bit_mask;
      end else begin
        root_acc <= root_acc >> 1;
      end
      bit_mask <= bit_mask >> 2;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sobel_edge_detector.sv]
`default_nettype none

// Throughput: one pixel at a time; a new pixel is accepted only in ST_IDLE, after the
//   previous one has passed the line store read-modify-write and, if it gives a
//   result, the 11-step square root and the output load, which waits for m_axis.
// Reset (rst, synchronous): counters to row 0 / column 0, window to zero,
//   line_width 16, edge_threshold 100; line stores are not cleared.
module sobel_edge_detector #(
  parameter int MAX_LINE_WIDTH = sed_pkg::DEF_MAX_LINE_WIDTH,
  parameter int MAX_ROWS       = sed_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  // pixel stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sed_pkg::PIXEL_W-1:0]    s_axis_tdata,  // [7:0] pixel
  input  logic                           s_axis_tuser,  // [0] frame_start
  // gradient results out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [9:0] center_row, [19:10] center_col, [30:20] grad_x, [41:31] grad_y,
  // [52:42] magnitude, [53] edge_res, [55:54] zero
  output logic [sed_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [sed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sed_pkg::CFG_W-1:0]      cfg_data
);

  import sed_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE_WIDTH);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] line_width;
  logic [CFG_W-1:0] edge_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width     <= RST_LINE_WIDTH;
      edge_threshold <= RST_EDGE_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:     line_width     <= cfg_data;
        REG_EDGE_THRESHOLD: edge_threshold <= cfg_data;
        default:            ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Control FSM: one pixel at a time through read and window update,
  // then, if it gives a result, gradient, squares, root and output load.
  // ---------------------------------------------------------------------
  sed_state_t state, state_next;

  logic in_acc;
  logic emit_q;
  logic sqrt_start;
  logic sqrt_done;
  logic out_load;
  logic out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    sqrt_start    = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        // store data is valid here; window and stores update
        state_next = emit_q ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: state_next = ST_SQR;
      ST_SQR:  state_next = ST_SUM;
      ST_SUM: begin
        sqrt_start = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------
  // Raster position
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic [CMP_W-1:0] width_eff;
  logic             row_end;

  // frame_start restarts at row 0, column 0 on this very pixel
  assign col_cur = s_axis_tuser ? '0 : column_count;
  assign row_cur = s_axis_tuser ? '0 : row_count;
  assign col_inc = {1'b0, col_cur} + 1'b1;
  assign row_inc = {1'b0, row_cur} + 1'b1;

  // out-of-range widths clamp to [3, MAX_LINE_WIDTH]
  always_comb begin
    width_eff = CMP_W'(line_width);
    if (width_eff < CMP_W'(MIN_LINE_WIDTH)) begin
      width_eff = CMP_W'(MIN_LINE_WIDTH);
    end else if (width_eff > CMP_W'(MAX_LINE_WIDTH)) begin
      width_eff = CMP_W'(MAX_LINE_WIDTH);
    end
  end

  // also ends the row when the width shrank below the current column
  assign row_end = CMP_W'(col_inc) >= width_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_acc) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= (row_inc >= (ROW_W + 1)'(MAX_ROWS)) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        column_count <= col_inc[COL_W-1:0];
        row_count    <= row_cur;
      end
    end
  end

  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [PIXEL_W-1:0] px_q;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      col_q <= col_cur;
      row_q <= row_cur;
      px_q  <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_q <= 1'b0;
    end else if (in_acc) begin
      emit_q <= (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
    end
  end

  // ---------------------------------------------------------------------
  // Line stores: one memory, word = {upper, middle}. Read at accept,
  // written back shifted down one row in the next cycle.
  // ---------------------------------------------------------------------
  logic [2*PIXEL_W-1:0] ram_rd;
  logic [2*PIXEL_W-1:0] ram_wr;
  logic                 ram_we;
  logic [PIXEL_W-1:0]   rd_upper;
  logic [PIXEL_W-1:0]   rd_middle;

  assign rd_upper  = ram_rd[2*PIXEL_W-1:PIXEL_W];
  assign rd_middle = ram_rd[PIXEL_W-1:0];
  assign ram_we    = (state == ST_READ);
  assign ram_wr    = {rd_middle, px_q};

  sed_ram #(
    .WIDTH (2 * PIXEL_W),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (col_q),
    .wr_data (ram_wr),
    .rd_addr (col_cur),
    .rd_data (ram_rd)
  );

  // ---------------------------------------------------------------------
  // 3x3 window: rows top/middle/bottom, columns shift left each pixel
  // ---------------------------------------------------------------------
  logic [PIXEL_W-1:0] window [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        window[i] <= '0;
      end
    end else if (state == ST_READ) begin
      for (int r = 0; r < 3; r++) begin
        window[r*3]     <= window[r*3 + 1];
        window[r*3 + 1] <= window[r*3 + 2];
      end
      window[2] <= rd_upper;
      window[5] <= rd_middle;
      window[8] <= px_q;
    end
  end

  // ---------------------------------------------------------------------
  // Gradients, squares, threshold compare
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0]         sum_r, sum_l, sum_b, sum_t;
  logic [GRAD_W:0]          gx_wide, gy_wide;
  logic signed [GRAD_W-1:0] gx_q, gy_q;

  assign sum_r = SUM_W'(window[2]) + SUM_W'({window[5], 1'b0}) + SUM_W'(window[8]);
  assign sum_l = SUM_W'(window[0]) + SUM_W'({window[3], 1'b0}) + SUM_W'(window[6]);
  assign sum_b = SUM_W'(window[6]) + SUM_W'({window[7], 1'b0}) + SUM_W'(window[8]);
  assign sum_t = SUM_W'(window[0]) + SUM_W'({window[1], 1'b0}) + SUM_W'(window[2]);
  assign gx_wide = (GRAD_W + 1)'(sum_r) - (GRAD_W + 1)'(sum_l);
  assign gy_wide = (GRAD_W + 1)'(sum_b) - (GRAD_W + 1)'(sum_t);

  always_ff @(posedge clk) begin
    if (state == ST_GRAD) begin
      gx_q <= signed'(gx_wide[GRAD_W-1:0]);
      gy_q <= signed'(gy_wide[GRAD_W-1:0]);
    end
  end

  logic signed [2*GRAD_W-1:0] gx_prod, gy_prod;
  logic [SQ_W-1:0]            thr_prod;
  logic [PROD_W-1:0]          gx2_q, gy2_q;
  logic [SQ_W-1:0]            thr2_q;
  logic [SQ_W-1:0]            sq_sum;
  logic                       edge_q;

  assign gx_prod  = gx_q * gx_q;
  assign gy_prod  = gy_q * gy_q;
  assign thr_prod = {{(SQ_W - CFG_W){1'b0}}, edge_threshold}
                  * {{(SQ_W - CFG_W){1'b0}}, edge_threshold};

  always_ff @(posedge clk) begin
    if (state == ST_SQR) begin
      gx2_q  <= gx_prod[PROD_W-1:0];
      gy2_q  <= gy_prod[PROD_W-1:0];
      thr2_q <= thr_prod;
    end
  end

  assign sq_sum = SQ_W'(gx2_q) + SQ_W'(gy2_q);

  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      edge_q <= sq_sum > thr2_q;
    end
  end

  logic [MAG_W-1:0] mag;

  sed_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .operand (sq_sum),
    .done    (sqrt_done),
    .root    (mag)
  );

  // ---------------------------------------------------------------------
  // Output register: holds a word while the next pixel is taken in
  // ---------------------------------------------------------------------
  logic [ROW_W-1:0]    row_m1;
  logic [COL_W-1:0]    col_m1;
  logic [CENTER_W-1:0] center_row;
  logic [CENTER_W-1:0] center_col;

  assign row_m1     = row_q - 1'b1;
  assign col_m1     = col_q - 1'b1;
  assign center_row = CENTER_W'(row_m1);
  assign center_col = CENTER_W'(col_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {{OUT_PAD_W{1'b0}}, edge_q, mag, gy_q, gx_q, center_col, center_row};
    end
  end

endmodule

`default_nettype wire
